// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the servo controller core modules.
// Standalone header; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/scp_pkg.sv =====
// Shared types and constants for the servo position controller core.
// No dependencies; used by every module of the core.
package scp_pkg;

    typedef struct packed {
        logic [1:0]  func;
        logic [13:0] enc_sample;
        logic [7:0]  frame_b0;
        logic [7:0]  frame_b1;
        logic [7:0]  frame_b2;
        logic [7:0]  frame_b3;
        logic [7:0]  frame_b4;
    } item_t;

    typedef struct packed {
        logic [11:0] pulse_width;
        logic        moving;
        logic [15:0] position;
        logic        reply_valid;
        logic [7:0]  reply_b0;
        logic [7:0]  reply_b1;
        logic [7:0]  reply_b2;
        logic [7:0]  reply_b3;
        logic [7:0]  reply_b4;
    } result_t;

    typedef struct packed {
        logic [9:0] dead_band;
        logic [7:0] min_offset;
        logic [9:0] manual_max_offset;
        logic [7:0] loop_max_offset;
    } cfg_t;

    typedef enum logic [2:0] {
        PULSE_HOLD,
        PULSE_CENTRE,
        PULSE_LOOP_MINUS,
        PULSE_LOOP_PLUS,
        PULSE_MAN_PLUS,
        PULSE_MAN_MINUS
    } pulse_cmd_t;

    // Word passed from the tracking stage to the pulse stage.
    typedef struct packed {
        pulse_cmd_t  cmd;
        logic [14:0] loop_mag;
        logic [17:0] man_prod;
        logic        moving;
        logic [15:0] position;
        logic        reply_valid;
        logic [15:0] reply_target;
    } exec_word_t;

    localparam logic [1:0] REG_DEAD_BAND  = 2'd0;
    localparam logic [1:0] REG_MIN_OFFSET = 2'd1;
    localparam logic [1:0] REG_MAN_MAX    = 2'd2;
    localparam logic [1:0] REG_LOOP_MAX   = 2'd3;

    localparam logic [9:0] RST_DEAD_BAND  = 10'd50;
    localparam logic [7:0] RST_MIN_OFFSET = 8'd63;
    localparam logic [9:0] RST_MAN_MAX    = 10'd700;
    localparam logic [7:0] RST_LOOP_MAX   = 8'd100;

    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_FRAME  = 2'd2;

    localparam logic [7:0] SYNC_BYTE   = 8'hff;
    localparam logic [7:0] CODE_ROTATE = 8'h07;
    localparam logic [7:0] CODE_SET    = 8'h12;
    localparam logic [7:0] CODE_QUERY  = 8'h14;
    localparam logic [7:0] CODE_REPLY  = 8'h24;

    localparam logic [7:0] DIR_STOP  = 8'd0;
    localparam logic [7:0] DIR_PLUS  = 8'd1;
    localparam logic [7:0] DIR_MINUS = 8'd2;

    localparam logic [11:0] CENTRE_US = 12'd1500;

    localparam int POS_MOD      = 49151;
    localparam int HALF_POS     = 24575;
    localparam int TWO_HALF_POS = 2 * HALF_POS;
    localparam int ENC_SPAN     = 16384;
    localparam int WRAP_LIMIT   = 15000;
    localparam int FAR_LIMIT    = 49122;

    // Reciprocal multipliers: x / 10 for x < 24575, x / 100 for x < 2^18.
    localparam logic [15:0] DIV10_MULT   = 16'd52429;
    localparam int          DIV10_SHIFT  = 19;
    localparam logic [19:0] DIV100_MULT  = 20'd671089;
    localparam int          DIV100_SHIFT = 26;

endpackage

// ===== rtl/core/scp_cfg_regs.sv =====
// Configuration register file for the servo position controller core.
// Depends on scp_pkg for the register indexes, reset values and cfg_t.
module scp_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [9:0]         wr_data,
    output scp_pkg::cfg_t      cfg
);

    scp_pkg::cfg_t cfg_reg;
    scp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                scp_pkg::REG_DEAD_BAND:  cfg_next.dead_band         = wr_data;
                scp_pkg::REG_MIN_OFFSET: cfg_next.min_offset        = wr_data[7:0];
                scp_pkg::REG_MAN_MAX:    cfg_next.manual_max_offset = wr_data;
                scp_pkg::REG_LOOP_MAX:   cfg_next.loop_max_offset   = wr_data[7:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dead_band         <= scp_pkg::RST_DEAD_BAND;
            cfg_reg.min_offset        <= scp_pkg::RST_MIN_OFFSET;
            cfg_reg.manual_max_offset <= scp_pkg::RST_MAN_MAX;
            cfg_reg.loop_max_offset   <= scp_pkg::RST_LOOP_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/scp_tracker.sv =====
// Tracking stage: position unwrap, loop error, frame decode and reply hold-back.
// Depends on scp_pkg and assert_macros.svh; feeds scp_pulse_out with exec_word_t.
`include "assert_macros.svh"

module scp_tracker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid,
    output logic                  ready,
    input  scp_pkg::item_t        item,
    input  scp_pkg::cfg_t         cfg,
    output logic                  word_valid,
    input  logic                  word_ready,
    output scp_pkg::exec_word_t   word
);

    logic [15:0] pos_reg, pos_next;
    logic [13:0] last_reg, last_next;
    logic        first_reg, first_next;
    logic [15:0] target_reg, target_next;
    logic        loop_en_reg, loop_en_next;
    logic        moving_reg, moving_next;
    logic        pending_reg, pending_next;
    logic [15:0] reply_target_reg, reply_target_next;
    logic        word_valid_reg, word_valid_next;
    scp_pkg::exec_word_t word_reg, word_next;

    logic               fire;
    logic               release_now;
    scp_pkg::pulse_cmd_t cmd;

    logic signed [17:0] delta_raw, delta, pos_sum;
    logic [15:0]        pos_wrapped;
    logic signed [17:0] err;
    logic [16:0]        mag;
    logic [14:0]        loop_mag;
    logic               tick_drive, tick_minus;
    logic [9:0]         span;
    logic [17:0]        man_prod;
    logic [7:0]         frame_sum;
    logic               frame_ok;

    assign ready = !word_valid_reg || word_ready;
    assign fire  = valid && ready;

    // Encoder unwrap and position wrap.
    always_comb
    begin
        delta_raw = $signed({4'b0, item.enc_sample}) - $signed({4'b0, last_reg});
        if (delta_raw > scp_pkg::WRAP_LIMIT)
            delta = 18'(delta_raw - scp_pkg::ENC_SPAN);
        else if (delta_raw < -scp_pkg::WRAP_LIMIT)
            delta = 18'(delta_raw + scp_pkg::ENC_SPAN);
        else
            delta = delta_raw;
        pos_sum = $signed({2'b0, pos_reg}) + delta;
        if (pos_sum > scp_pkg::POS_MOD)
            pos_wrapped = 16'(pos_sum - scp_pkg::POS_MOD);
        else if (pos_sum < 0)
            pos_wrapped = 16'(pos_sum + scp_pkg::POS_MOD);
        else
            pos_wrapped = 16'(pos_sum);
    end

    // Loop error, its magnitude folded below half a range, and direction.
    always_comb
    begin
        err = $signed({2'b0, target_reg}) - $signed({2'b0, pos_reg});
        mag = err[17] ? 17'(-err) : 17'(err);
        if (mag >= 17'(scp_pkg::TWO_HALF_POS))
            loop_mag = 15'(mag - 17'(scp_pkg::TWO_HALF_POS));
        else if (mag >= 17'(scp_pkg::HALF_POS))
            loop_mag = 15'(mag - 17'(scp_pkg::HALF_POS));
        else
            loop_mag = mag[14:0];
        tick_drive = (mag > {7'b0, cfg.dead_band}) && (mag < 17'(scp_pkg::FAR_LIMIT));
        tick_minus = ((err > 0) && (err < scp_pkg::HALF_POS)) || (err < -scp_pkg::HALF_POS);
    end

    // Manual speed product; the division by 100 happens in the pulse stage.
    always_comb
    begin
        if (cfg.manual_max_offset > {2'b0, cfg.min_offset})
            span = cfg.manual_max_offset - {2'b0, cfg.min_offset};
        else
            span = '0;
        man_prod = {10'b0, item.frame_b2} * {8'b0, span};
    end

    assign frame_sum = 8'(item.frame_b1 + item.frame_b2 + item.frame_b3);
    assign frame_ok  = (item.frame_b0 == scp_pkg::SYNC_BYTE) && (item.frame_b4 == frame_sum);

    always_comb
    begin
        pos_next          = pos_reg;
        last_next         = last_reg;
        first_next        = first_reg;
        target_next       = target_reg;
        loop_en_next      = loop_en_reg;
        moving_next       = moving_reg;
        pending_next      = pending_reg;
        reply_target_next = reply_target_reg;
        cmd               = scp_pkg::PULSE_HOLD;
        release_now       = 1'b0;
        word_valid_next   = word_valid_reg;
        word_next         = word_reg;

        if (word_ready)
            word_valid_next = 1'b0;

        if (fire)
        begin
            case (item.func)
                scp_pkg::FUNC_SAMPLE:
                begin
                    last_next = item.enc_sample;
                    if (first_reg)
                    begin
                        pos_next   = {2'b0, item.enc_sample};
                        first_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_wrapped;
                    end
                end
                scp_pkg::FUNC_TICK:
                begin
                    if (loop_en_reg)
                    begin
                        moving_next = tick_drive;
                        if (!tick_drive)
                            cmd = scp_pkg::PULSE_CENTRE;
                        else if (tick_minus)
                            cmd = scp_pkg::PULSE_LOOP_MINUS;
                        else
                            cmd = scp_pkg::PULSE_LOOP_PLUS;
                    end
                end
                scp_pkg::FUNC_FRAME:
                begin
                    if (frame_ok)
                    begin
                        case (item.frame_b1)
                            scp_pkg::CODE_ROTATE:
                            begin
                                if (item.frame_b3 == scp_pkg::DIR_STOP)
                                begin
                                    cmd          = scp_pkg::PULSE_CENTRE;
                                    target_next  = pos_reg;
                                    moving_next  = 1'b0;
                                    loop_en_next = 1'b1;
                                end
                                else
                                begin
                                    loop_en_next = 1'b0;
                                    moving_next  = 1'b1;
                                    if (item.frame_b3 == scp_pkg::DIR_PLUS)
                                        cmd = scp_pkg::PULSE_MAN_PLUS;
                                    else if (item.frame_b3 == scp_pkg::DIR_MINUS)
                                        cmd = scp_pkg::PULSE_MAN_MINUS;
                                end
                            end
                            scp_pkg::CODE_SET:
                            begin
                                target_next = {item.frame_b2, item.frame_b3};
                            end
                            scp_pkg::CODE_QUERY:
                            begin
                                reply_target_next = target_reg;
                                pending_next      = 1'b1;
                            end
                            default:
                            begin
                                cmd = scp_pkg::PULSE_HOLD;
                            end
                        endcase
                    end
                end
                default:
                begin
                    cmd = scp_pkg::PULSE_HOLD;
                end
            endcase

            // A held reply goes out once the servo is at rest.
            if (pending_next && !moving_next)
            begin
                release_now  = 1'b1;
                pending_next = 1'b0;
            end

            word_valid_next        = 1'b1;
            word_next.cmd          = cmd;
            word_next.loop_mag     = loop_mag;
            word_next.man_prod     = man_prod;
            word_next.moving       = moving_next;
            word_next.position     = pos_next;
            word_next.reply_valid  = release_now;
            word_next.reply_target = reply_target_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            last_reg         <= '0;
            first_reg        <= 1'b1;
            target_reg       <= '0;
            loop_en_reg      <= 1'b1;
            moving_reg       <= 1'b1;
            pending_reg      <= 1'b0;
            reply_target_reg <= '0;
            word_valid_reg   <= 1'b0;
        end
        else
        begin
            pos_reg          <= pos_next;
            last_reg         <= last_next;
            first_reg        <= first_next;
            target_reg       <= target_next;
            loop_en_reg      <= loop_en_next;
            moving_reg       <= moving_next;
            pending_reg      <= pending_next;
            reply_target_reg <= reply_target_next;
            word_valid_reg   <= word_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_valid = word_valid_reg;
    assign word       = word_reg;

    `ASSERT_IMPLIES(a_pending_while_moving, clk, rst_n, pending_reg, moving_reg, "reply held while at rest")
    `ASSERT_IMPLIES(a_pos_range, clk, rst_n, 1'b1, pos_reg <= 16'(scp_pkg::POS_MOD), "position out of range")
    `ASSERT_NEXT(a_reply_at_rest, clk, rst_n, fire && release_now, word_valid_reg && word_reg.reply_valid && !word_reg.moving, "reply word lost or moving")

endmodule

// ===== rtl/core/scp_pulse_out.sv =====
// Pulse stage and result register: offset scaling, clamping and reply framing.
// Depends on scp_pkg and assert_macros.svh; takes exec_word_t from scp_tracker.
`include "assert_macros.svh"

module scp_pulse_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  word_valid,
    output logic                  word_ready,
    input  scp_pkg::exec_word_t   word,
    input  scp_pkg::cfg_t         cfg,
    output logic                  result_valid,
    input  logic                  result_ready,
    output scp_pkg::result_t      result
);

    logic [11:0]      pulse_reg, pulse_next;
    logic             result_valid_reg, result_valid_next;
    scp_pkg::result_t result_reg, result_next;

    logic        fire;
    logic [30:0] loop_prod;
    logic [11:0] loop_quot;
    logic [7:0]  loop_capped;
    logic [7:0]  loop_off;
    logic [37:0] man_full;
    logic [11:0] man_quot;
    logic [12:0] man_sum;
    logic [9:0]  man_off;
    logic [7:0]  hi_byte, lo_byte;

    assign word_ready = !result_valid_reg || result_ready;
    assign fire       = word_valid && word_ready;

    always_comb
    begin
        loop_prod = {16'b0, word.loop_mag} * {15'b0, scp_pkg::DIV10_MULT};
        loop_quot = loop_prod[scp_pkg::DIV10_SHIFT +: 12];
        if (loop_quot > {4'b0, cfg.loop_max_offset})
            loop_capped = cfg.loop_max_offset;
        else
            loop_capped = loop_quot[7:0];
        if (loop_capped < cfg.min_offset)
            loop_off = cfg.min_offset;
        else
            loop_off = loop_capped;
    end

    always_comb
    begin
        man_full = {20'b0, word.man_prod} * {18'b0, scp_pkg::DIV100_MULT};
        man_quot = man_full[scp_pkg::DIV100_SHIFT +: 12];
        man_sum  = {1'b0, man_quot} + {5'b0, cfg.min_offset};
        if (man_sum > {3'b0, cfg.manual_max_offset})
            man_off = cfg.manual_max_offset;
        else
            man_off = man_sum[9:0];
    end

    always_comb
    begin
        case (word.cmd)
            scp_pkg::PULSE_HOLD:       pulse_next = pulse_reg;
            scp_pkg::PULSE_CENTRE:     pulse_next = scp_pkg::CENTRE_US;
            scp_pkg::PULSE_LOOP_MINUS: pulse_next = scp_pkg::CENTRE_US - {4'b0, loop_off};
            scp_pkg::PULSE_LOOP_PLUS:  pulse_next = scp_pkg::CENTRE_US + {4'b0, loop_off};
            scp_pkg::PULSE_MAN_PLUS:   pulse_next = scp_pkg::CENTRE_US + {2'b0, man_off};
            scp_pkg::PULSE_MAN_MINUS:  pulse_next = scp_pkg::CENTRE_US - {2'b0, man_off};
            default:                   pulse_next = pulse_reg;
        endcase
    end

    assign hi_byte = word.reply_target[15:8];
    assign lo_byte = word.reply_target[7:0];

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (result_ready)
            result_valid_next = 1'b0;
        if (fire)
        begin
            result_valid_next       = 1'b1;
            result_next.pulse_width = pulse_next;
            result_next.moving      = word.moving;
            result_next.position    = word.position;
            result_next.reply_valid = word.reply_valid;
            if (word.reply_valid)
            begin
                result_next.reply_b0 = scp_pkg::SYNC_BYTE;
                result_next.reply_b1 = scp_pkg::CODE_REPLY;
                result_next.reply_b2 = hi_byte;
                result_next.reply_b3 = lo_byte;
                result_next.reply_b4 = 8'(scp_pkg::CODE_REPLY + hi_byte + lo_byte);
            end
            else
            begin
                result_next.reply_b0 = '0;
                result_next.reply_b1 = '0;
                result_next.reply_b2 = '0;
                result_next.reply_b3 = '0;
                result_next.reply_b4 = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                pulse_reg <= pulse_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_IMPLIES(a_rest_is_centre, clk, rst_n, result_valid_reg && !result_reg.moving, result_reg.pulse_width == scp_pkg::CENTRE_US, "at rest off centre pulse")

endmodule

// ===== rtl/core/servo_position_controller_core.sv =====
// Path: an item goes through the input, tracking and result registers, in that order.
// Throughput: one word per cycle while result_ready is high; a low result_ready stalls
// the stages back to item_ready. The tracking state updates once per word.
// Reset: asynchronous active-low; configuration returns to its defaults, all
// pipeline stages empty, pulse width 0, moving set, position 0 until the first sample.
// Depends on scp_pkg, scp_cfg_regs, scp_tracker and scp_pulse_out.
module servo_position_controller_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  scp_pkg::item_t     item,
    output logic               result_valid,
    input  logic               result_ready,
    output scp_pkg::result_t   result,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [9:0]         wr_data
);

    logic                s1_valid_reg, s1_valid_next;
    scp_pkg::item_t      s1_item_reg;
    logic                trk_ready;
    logic                word_valid;
    logic                word_ready;
    scp_pkg::exec_word_t word;
    scp_pkg::cfg_t       cfg;

    assign item_ready = !s1_valid_reg || trk_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_ready)
            s1_valid_next = item_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            s1_item_reg <= item;
    end

    scp_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    scp_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (s1_valid_reg),
        .ready      (trk_ready),
        .item       (s1_item_reg),
        .cfg        (cfg),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word)
    );

    scp_pulse_out u_pulse (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (word_valid),
        .word_ready   (word_ready),
        .word         (word),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
